[rtl/tcce_pkg.sv]
`default_nettype none

package tcce_pkg;

    localparam int COLUMNS_DEF = 52;
    localparam int ROWS_DEF    = 29;

    localparam int CELL_W      = 6;
    localparam int CELL_H      = 8;
    localparam int ORIGIN      = 6;
    localparam int TAB_STOP    = 4;
    localparam int GLYPH_FIRST = 32;
    localparam int GLYPH_COUNT = 96;
    localparam int GLYPH_BITS  = 35;
    localparam int COLOUR_W    = 16;

    typedef logic [1:0]            op_t;
    typedef logic [COLOUR_W-1:0]   colour_t;
    typedef logic [GLYPH_BITS-1:0] glyph_t;

    localparam op_t OP_NONE  = 2'd0;
    localparam op_t OP_FILL  = 2'd1;
    localparam op_t OP_GLYPH = 2'd2;
    localparam op_t OP_CLEAR = 2'd3;

    localparam colour_t FORE_RESET = 16'hFFFF;
    localparam colour_t BACK_RESET = 16'h0000;

    localparam logic REG_FORE = 1'b0;
    localparam logic REG_BACK = 1'b1;

    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

`default_nettype wire

[rtl/tcce_font_rom.sv]
`default_nettype none

module tcce_font_rom (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [7:0]           rd_code,
    output      tcce_pkg::glyph_t     rd_glyph
);

    tcce_pkg::glyph_t glyph_reg;
    logic [7:0]       idx_full;
    logic [39:0]      raw;
    tcce_pkg::glyph_t packed_glyph;
    logic             in_range;

    // five font bytes per glyph, first column in the top byte
    function automatic logic [39:0] font_row(input logic [6:0] idx);
        logic [39:0] r;
        case (idx)
            7'd0:  r = 40'h00_00_00_00_00;
            7'd1:  r = 40'h00_00_5F_00_00;
            7'd2:  r = 40'h00_07_00_07_00;
            7'd3:  r = 40'h14_7F_14_7F_14;
            7'd4:  r = 40'h24_2A_7F_2A_12;
            7'd5:  r = 40'h23_13_08_64_62;
            7'd6:  r = 40'h36_49_55_22_50;
            7'd7:  r = 40'h00_05_03_00_00;
            7'd8:  r = 40'h00_1C_22_41_00;
            7'd9:  r = 40'h00_41_22_1C_00;
            7'd10: r = 40'h08_2A_1C_2A_08;
            7'd11: r = 40'h08_08_3E_08_08;
            7'd12: r = 40'h00_50_30_00_00;
            7'd13: r = 40'h08_08_08_08_08;
            7'd14: r = 40'h00_60_60_00_00;
            7'd15: r = 40'h20_10_08_04_02;
            7'd16: r = 40'h3E_51_49_45_3E;
            7'd17: r = 40'h00_42_7F_40_00;
            7'd18: r = 40'h42_61_51_49_46;
            7'd19: r = 40'h21_41_45_4B_31;
            7'd20: r = 40'h18_14_12_7F_10;
            7'd21: r = 40'h27_45_45_45_39;
            7'd22: r = 40'h3C_4A_49_49_30;
            7'd23: r = 40'h01_71_09_05_03;
            7'd24: r = 40'h36_49_49_49_36;
            7'd25: r = 40'h06_49_49_29_1E;
            7'd26: r = 40'h00_36_36_00_00;
            7'd27: r = 40'h00_56_36_00_00;
            7'd28: r = 40'h00_08_14_22_41;
            7'd29: r = 40'h14_14_14_14_14;
            7'd30: r = 40'h41_22_14_08_00;
            7'd31: r = 40'h02_01_51_09_06;
            7'd32: r = 40'h32_49_79_41_3E;
            7'd33: r = 40'h7E_11_11_11_7E;
            7'd34: r = 40'h7F_49_49_49_36;
            7'd35: r = 40'h3E_41_41_41_22;
            7'd36: r = 40'h7F_41_41_22_1C;
            7'd37: r = 40'h7F_49_49_49_41;
            7'd38: r = 40'h7F_09_09_01_01;
            7'd39: r = 40'h3E_41_41_51_32;
            7'd40: r = 40'h7F_08_08_08_7F;
            7'd41: r = 40'h00_41_7F_41_00;
            7'd42: r = 40'h20_40_41_3F_01;
            7'd43: r = 40'h7F_08_14_22_41;
            7'd44: r = 40'h7F_40_40_40_40;
            7'd45: r = 40'h7F_02_04_02_7F;
            7'd46: r = 40'h7F_04_08_10_7F;
            7'd47: r = 40'h3E_41_41_41_3E;
            7'd48: r = 40'h7F_09_09_09_06;
            7'd49: r = 40'h3E_41_51_21_5E;
            7'd50: r = 40'h7F_09_19_29_46;
            7'd51: r = 40'h46_49_49_49_31;
            7'd52: r = 40'h01_01_7F_01_01;
            7'd53: r = 40'h3F_40_40_40_3F;
            7'd54: r = 40'h1F_20_40_20_1F;
            7'd55: r = 40'h7F_20_18_20_7F;
            7'd56: r = 40'h63_14_08_14_63;
            7'd57: r = 40'h03_04_78_04_03;
            7'd58: r = 40'h61_51_49_45_43;
            7'd59: r = 40'h00_00_7F_41_41;
            7'd60: r = 40'h02_04_08_10_20;
            7'd61: r = 40'h41_41_7F_00_00;
            7'd62: r = 40'h04_02_01_02_04;
            7'd63: r = 40'h40_40_40_40_40;
            7'd64: r = 40'h00_01_02_04_00;
            7'd65: r = 40'h20_54_54_54_78;
            7'd66: r = 40'h7F_48_44_44_38;
            7'd67: r = 40'h38_44_44_44_20;
            7'd68: r = 40'h38_44_44_48_7F;
            7'd69: r = 40'h38_54_54_54_18;
            7'd70: r = 40'h08_7E_09_01_02;
            7'd71: r = 40'h08_14_54_54_3C;
            7'd72: r = 40'h7F_08_04_04_78;
            7'd73: r = 40'h00_44_7D_40_00;
            7'd74: r = 40'h20_40_44_3D_00;
            7'd75: r = 40'h00_7F_10_28_44;
            7'd76: r = 40'h00_41_7F_40_00;
            7'd77: r = 40'h7C_04_18_04_78;
            7'd78: r = 40'h7C_08_04_04_78;
            7'd79: r = 40'h38_44_44_44_38;
            7'd80: r = 40'h7C_14_14_14_08;
            7'd81: r = 40'h08_14_14_18_7C;
            7'd82: r = 40'h7C_08_04_04_08;
            7'd83: r = 40'h48_54_54_54_20;
            7'd84: r = 40'h04_3F_44_40_20;
            7'd85: r = 40'h3C_40_40_20_7C;
            7'd86: r = 40'h1C_20_40_20_1C;
            7'd87: r = 40'h3C_40_30_40_3C;
            7'd88: r = 40'h44_28_10_28_44;
            7'd89: r = 40'h0C_50_50_50_3C;
            7'd90: r = 40'h44_64_54_4C_44;
            7'd91: r = 40'h00_08_36_41_00;
            7'd92: r = 40'h00_00_7F_00_00;
            7'd93: r = 40'h00_41_36_08_00;
            7'd94: r = 40'h08_08_2A_1C_08;
            7'd95: r = 40'h08_1C_2A_08_08;
            default: r = 40'h0;
        endcase
        return r;
    endfunction

    assign idx_full = rd_code - 8'(tcce_pkg::GLYPH_FIRST);
    assign in_range = (rd_code >= 8'(tcce_pkg::GLYPH_FIRST)) &&
                      (idx_full < 8'(tcce_pkg::GLYPH_COUNT));
    assign raw      = font_row(idx_full[6:0]);

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            packed_glyph[7*k +: 7] = raw[8*(4-k) +: 7];
        end
    end

    // synchronous read, codes outside the font give a blank glyph
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            glyph_reg <= in_range ? packed_glyph : '0;
        end
    end

    assign rd_glyph = glyph_reg;

endmodule

`default_nettype wire

[rtl/text_console_cursor_engine.sv]
`default_nettype none

// Character terminal cursor engine. Each character word taken on the s_ side is
// turned into one to five drawing command words on the m_ side (no drawing, fill a
// 6x8 cell, draw a 5x7 glyph, clear screen), with the final one flagged by m_last.
// The cursor wraps at COLUMNS and clears the screen when it passes ROWS. Colours
// come from two registers written through cfg_we/cfg_index/cfg_data. The font memory
// is read as the word is taken; the command sequencer then issues one command per
// cycle while m_ready is high. s_ready is high only while the sequencer is idle.
module text_console_cursor_engine #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_we,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,

    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic [7:0]           s_char_code,

    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      logic [1:0]           m_op_kind,
    output      logic [8:0]           m_pixel_x,
    output      logic [7:0]           m_pixel_y,
    output      logic [34:0]          m_glyph_bits,
    output      logic [15:0]          m_draw_fore,
    output      logic [15:0]          m_draw_back,
    output      logic                 m_last
);

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    localparam logic [2:0] CLS_NL    = 3'd0;
    localparam logic [2:0] CLS_BS    = 3'd1;
    localparam logic [2:0] CLS_FF    = 3'd2;
    localparam logic [2:0] CLS_ETX   = 3'd3;
    localparam logic [2:0] CLS_BEL   = 3'd4;
    localparam logic [2:0] CLS_FILL  = 3'd5;
    localparam logic [2:0] CLS_GLYPH = 3'd6;

    logic                 state_reg, state_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [2:0]           cls_reg, cls_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    tcce_pkg::colour_t    fore_reg, back_reg;

    logic                 m_valid_reg, m_valid_next;
    tcce_pkg::op_t        op_reg;
    logic [8:0]           px_reg;
    logic [7:0]           py_reg;
    tcce_pkg::glyph_t     glyph_out_reg;
    tcce_pkg::colour_t    dfore_reg, dback_reg;
    logic                 last_reg;

    tcce_pkg::glyph_t     rom_glyph;
    logic                 accept;
    logic                 slot_free;

    logic [COL_W:0]       col_inc;
    logic [ROW_W:0]       row_inc;
    logic                 col_wrap, row_wrap;
    logic [COL_W-1:0]     col_adv;
    logic [ROW_W-1:0]     row_adv, row_nl;
    logic                 adv_clear;

    logic                 emit, e_last;
    tcce_pkg::op_t        e_op;
    logic [COL_W-1:0]     e_col;
    logic [ROW_W-1:0]     e_row;

    tcce_font_rom u_font (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_code  (s_char_code),
        .rd_glyph (rom_glyph)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // cursor arithmetic shared by advance and newline
    assign col_inc   = {1'b0, col_reg} + (COL_W+1)'(1);
    assign row_inc   = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign col_wrap  = col_inc >= (COL_W+1)'(COLUMNS);
    assign row_wrap  = row_inc >= (ROW_W+1)'(ROWS);
    assign row_nl    = row_wrap ? '0 : row_inc[ROW_W-1:0];
    assign col_adv   = col_wrap ? '0 : col_inc[COL_W-1:0];
    assign row_adv   = col_wrap ? row_nl : row_reg;
    assign adv_clear = col_wrap && row_wrap;

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cls_next   = cls_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        emit       = 1'b0;
        e_op       = tcce_pkg::OP_NONE;
        e_col      = col_reg;
        e_row      = row_reg;
        e_last     = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RUN;
                    pend_next  = 1'b0;
                    cnt_next   = 3'd1;
                    case (s_char_code)
                        tcce_pkg::CH_CR,
                        tcce_pkg::CH_LF:    cls_next = CLS_NL;
                        tcce_pkg::CH_BS:    cls_next = CLS_BS;
                        tcce_pkg::CH_FF:    cls_next = CLS_FF;
                        tcce_pkg::CH_ETX:   cls_next = CLS_ETX;
                        tcce_pkg::CH_BEL:   cls_next = CLS_BEL;
                        tcce_pkg::CH_SPACE: cls_next = CLS_FILL;
                        tcce_pkg::CH_TAB: begin
                            // tab stops every four columns: low two bits give column mod 4
                            cls_next = CLS_FILL;
                            cnt_next = 3'(tcce_pkg::TAB_STOP) - {1'b0, col_reg[1:0]};
                        end
                        default:            cls_next = CLS_GLYPH;
                    endcase
                end
            end
            S_RUN: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (pend_reg) begin
                        // clear caused by the previous advance
                        e_op      = tcce_pkg::OP_CLEAR;
                        e_last    = (cnt_reg == 3'd0);
                        pend_next = 1'b0;
                    end else begin
                        case (cls_reg)
                            CLS_NL: begin
                                e_op     = row_wrap ? tcce_pkg::OP_CLEAR : tcce_pkg::OP_NONE;
                                col_next = '0;
                                row_next = row_nl;
                            end
                            CLS_BS: begin
                                e_op = tcce_pkg::OP_FILL;
                                if (col_reg != '0) begin
                                    e_col = col_reg - COL_W'(1);
                                end else if (row_reg != '0) begin
                                    e_col = COL_W'(COLUMNS - 1);
                                    e_row = row_reg - ROW_W'(1);
                                end
                                col_next = e_col;
                                row_next = e_row;
                            end
                            CLS_FF: begin
                                e_op     = tcce_pkg::OP_CLEAR;
                                col_next = '0;
                                row_next = '0;
                            end
                            CLS_ETX: begin
                                col_next = '0;
                                row_next = '0;
                            end
                            CLS_BEL: begin
                                e_op     = adv_clear ? tcce_pkg::OP_CLEAR : tcce_pkg::OP_NONE;
                                col_next = col_adv;
                                row_next = row_adv;
                            end
                            CLS_FILL,
                            CLS_GLYPH: begin
                                e_op      = (cls_reg == CLS_GLYPH) ? tcce_pkg::OP_GLYPH
                                                                   : tcce_pkg::OP_FILL;
                                col_next  = col_adv;
                                row_next  = row_adv;
                                cnt_next  = cnt_reg - 3'd1;
                                pend_next = adv_clear;
                                e_last    = !adv_clear && (cnt_reg == 3'd1);
                            end
                            default: begin
                                e_op = tcce_pkg::OP_NONE;
                            end
                        endcase
                    end
                    if (e_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            cls_reg     <= CLS_NL;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            fore_reg    <= tcce_pkg::FORE_RESET;
            back_reg    <= tcce_pkg::BACK_RESET;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            cls_reg     <= cls_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                if (cfg_index == tcce_pkg::REG_FORE) begin
                    fore_reg <= cfg_data;
                end else begin
                    back_reg <= cfg_data;
                end
            end
        end
    end

    // output word register, unused fields forced to zero
    always_ff @(posedge aclk) begin
        if (emit) begin
            op_reg   <= e_op;
            last_reg <= e_last;
            if (e_op == tcce_pkg::OP_FILL || e_op == tcce_pkg::OP_GLYPH) begin
                px_reg <= 9'(tcce_pkg::ORIGIN) + 9'(e_col) * 9'(tcce_pkg::CELL_W);
                py_reg <= 8'(tcce_pkg::ORIGIN) + 8'(e_row) * 8'(tcce_pkg::CELL_H);
            end else begin
                px_reg <= '0;
                py_reg <= '0;
            end
            glyph_out_reg <= (e_op == tcce_pkg::OP_GLYPH) ? rom_glyph : '0;
            dfore_reg     <= (e_op != tcce_pkg::OP_NONE) ? fore_reg : '0;
            dback_reg     <= (e_op != tcce_pkg::OP_NONE) ? back_reg : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_op_kind    = op_reg;
    assign m_pixel_x    = px_reg;
    assign m_pixel_y    = py_reg;
    assign m_glyph_bits = glyph_out_reg;
    assign m_draw_fore  = dfore_reg;
    assign m_draw_back  = dback_reg;
    assign m_last       = last_reg;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, col_reg} < (COL_W+1)'(COLUMNS))
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, row_reg} < (ROW_W+1)'(ROWS))
        else $error("cursor row out of range");

    a_glyph_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_op_kind != tcce_pkg::OP_GLYPH) |-> (m_glyph_bits == '0))
        else $error("glyph bits set on a non-glyph command");

    a_pend_tab: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == S_RUN && (cls_reg == CLS_FILL || cls_reg == CLS_GLYPH)))
        else $error("pending clear outside a fill or glyph sequence");

    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && state_next == S_IDLE) |=> (m_valid && m_last))
        else $error("sequence ended without a last word");
`endif

endmodule

`default_nettype wire

[tb/text_console_cursor_engine_tb.sv]
`default_nettype none

module text_console_cursor_engine_tb;
    import tcce_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_CHARS    = 65;

    // 5x7 font, five column bytes per glyph from code 32 upwards, bit 0 is the top pixel
    localparam logic [7:0] FONT_5X7 [GLYPH_COUNT*5] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00,
        8'h00, 8'h07, 8'h00, 8'h07, 8'h00, 8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14,
        8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12, 8'h23, 8'h13, 8'h08, 8'h64, 8'h62,
        8'h36, 8'h49, 8'h55, 8'h22, 8'h50, 8'h00, 8'h05, 8'h03, 8'h00, 8'h00,
        8'h00, 8'h1C, 8'h22, 8'h41, 8'h00, 8'h00, 8'h41, 8'h22, 8'h1C, 8'h00,
        8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08, 8'h08, 8'h08, 8'h3E, 8'h08, 8'h08,
        8'h00, 8'h50, 8'h30, 8'h00, 8'h00, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
        8'h00, 8'h60, 8'h60, 8'h00, 8'h00, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
        8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
        8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
        8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
        8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
        8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
        8'h00, 8'h36, 8'h36, 8'h00, 8'h00, 8'h00, 8'h56, 8'h36, 8'h00, 8'h00,
        8'h00, 8'h08, 8'h14, 8'h22, 8'h41, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
        8'h41, 8'h22, 8'h14, 8'h08, 8'h00, 8'h02, 8'h01, 8'h51, 8'h09, 8'h06,
        8'h32, 8'h49, 8'h79, 8'h41, 8'h3E, 8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E,
        8'h7F, 8'h49, 8'h49, 8'h49, 8'h36, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,
        8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,
        8'h7F, 8'h09, 8'h09, 8'h01, 8'h01, 8'h3E, 8'h41, 8'h41, 8'h51, 8'h32,
        8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,
        8'h20, 8'h40, 8'h41, 8'h3F, 8'h01, 8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,
        8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F,
        8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,
        8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,
        8'h7F, 8'h09, 8'h19, 8'h29, 8'h46, 8'h46, 8'h49, 8'h49, 8'h49, 8'h31,
        8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,
        8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F, 8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F,
        8'h63, 8'h14, 8'h08, 8'h14, 8'h63, 8'h03, 8'h04, 8'h78, 8'h04, 8'h03,
        8'h61, 8'h51, 8'h49, 8'h45, 8'h43, 8'h00, 8'h00, 8'h7F, 8'h41, 8'h41,
        8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h41, 8'h41, 8'h7F, 8'h00, 8'h00,
        8'h04, 8'h02, 8'h01, 8'h02, 8'h04, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h00, 8'h01, 8'h02, 8'h04, 8'h00, 8'h20, 8'h54, 8'h54, 8'h54, 8'h78,
        8'h7F, 8'h48, 8'h44, 8'h44, 8'h38, 8'h38, 8'h44, 8'h44, 8'h44, 8'h20,
        8'h38, 8'h44, 8'h44, 8'h48, 8'h7F, 8'h38, 8'h54, 8'h54, 8'h54, 8'h18,
        8'h08, 8'h7E, 8'h09, 8'h01, 8'h02, 8'h08, 8'h14, 8'h54, 8'h54, 8'h3C,
        8'h7F, 8'h08, 8'h04, 8'h04, 8'h78, 8'h00, 8'h44, 8'h7D, 8'h40, 8'h00,
        8'h20, 8'h40, 8'h44, 8'h3D, 8'h00, 8'h00, 8'h7F, 8'h10, 8'h28, 8'h44,
        8'h00, 8'h41, 8'h7F, 8'h40, 8'h00, 8'h7C, 8'h04, 8'h18, 8'h04, 8'h78,
        8'h7C, 8'h08, 8'h04, 8'h04, 8'h78, 8'h38, 8'h44, 8'h44, 8'h44, 8'h38,
        8'h7C, 8'h14, 8'h14, 8'h14, 8'h08, 8'h08, 8'h14, 8'h14, 8'h18, 8'h7C,
        8'h7C, 8'h08, 8'h04, 8'h04, 8'h08, 8'h48, 8'h54, 8'h54, 8'h54, 8'h20,
        8'h04, 8'h3F, 8'h44, 8'h40, 8'h20, 8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C,
        8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C, 8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C,
        8'h44, 8'h28, 8'h10, 8'h28, 8'h44, 8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C,
        8'h44, 8'h64, 8'h54, 8'h4C, 8'h44, 8'h00, 8'h08, 8'h36, 8'h41, 8'h00,
        8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h41, 8'h36, 8'h08, 8'h00,
        8'h08, 8'h08, 8'h2A, 8'h1C, 8'h08, 8'h08, 8'h1C, 8'h2A, 8'h08, 8'h08
    };

    typedef struct packed {
        op_t        op;
        logic [8:0] px;
        logic [7:0] py;
        glyph_t     glyph;
        colour_t    fore;
        colour_t    back;
        logic       last;
    } draw_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_op_kind;
    logic [8:0]  m_pixel_x;
    logic [7:0]  m_pixel_y;
    logic [34:0] m_glyph_bits;
    logic [15:0] m_draw_fore;
    logic [15:0] m_draw_back;
    logic        m_last;

    // predictor state
    int unsigned cur_col;
    int unsigned cur_row;
    colour_t     fore_q;
    colour_t     back_q;
    draw_cmd_t   step_cmds[$];
    draw_cmd_t   cmd_expect_q[$];
    draw_cmd_t   exp_cmd;

    // stimulus control
    int tx_gap_max;
    int rx_stall_max;
    int rx_hold_req = 0;
    int rx_stall;
    bit tx_valid_up = 1'b0;

    int chars_sent       = 0;
    int cmds_checked     = 0;
    int clears_predicted = 0;
    int settings_used    = 0;
    int mismatch_count   = 0;
    int stuck_cycles     = 0;

    text_console_cursor_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_code  (s_char_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_op_kind    (m_op_kind),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_glyph_bits (m_glyph_bits),
        .m_draw_fore  (m_draw_fore),
        .m_draw_back  (m_draw_back),
        .m_last       (m_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void emit_cmd(op_t op, glyph_t g);
        draw_cmd_t c;
        c = '0;
        c.op = op;
        if (op == OP_FILL || op == OP_GLYPH) begin
            c.px = 9'(ORIGIN + CELL_W * cur_col);
            c.py = 8'(ORIGIN + CELL_H * cur_row);
        end
        if (op == OP_GLYPH)
            c.glyph = g;
        if (op != OP_NONE) begin
            c.fore = fore_q;
            c.back = back_q;
        end
        step_cmds.push_back(c);
    endfunction

    function automatic void home_clear();
        cur_col = 0;
        cur_row = 0;
        clears_predicted++;
        emit_cmd(OP_CLEAR, '0);
    endfunction

    function automatic void line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS_DEF)
            home_clear();
    endfunction

    function automatic void step_right();
        cur_col++;
        if (cur_col >= COLUMNS_DEF)
            line_feed();
    endfunction

    // drawing commands caused by one character, appended to the expectation queue
    function automatic void predict_char(logic [7:0] code);
        int unsigned n;
        int          c;
        glyph_t      g;
        c = code;
        step_cmds.delete();
        case (code)
            CH_CR, CH_LF: line_feed();
            CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                end else if (cur_row > 0) begin
                    cur_col = COLUMNS_DEF - 1;
                    cur_row--;
                end
                emit_cmd(OP_FILL, '0);
            end
            CH_FF: home_clear();
            CH_TAB: begin
                // count fixed before the first step, a clear on the way does not stop it
                n = TAB_STOP - (cur_col % TAB_STOP);
                repeat (n) begin
                    emit_cmd(OP_FILL, '0);
                    step_right();
                end
            end
            CH_BEL: step_right();
            CH_ETX: begin
                cur_col = 0;
                cur_row = 0;
            end
            CH_SPACE: begin
                emit_cmd(OP_FILL, '0);
                step_right();
            end
            default: begin
                g = '0;
                if (c >= GLYPH_FIRST && c < GLYPH_FIRST + GLYPH_COUNT)
                    for (int k = 0; k < 5; k++)
                        g[7*k +: 7] = FONT_5X7[(c - GLYPH_FIRST) * 5 + k][6:0];
                emit_cmd(OP_GLYPH, g);
                step_right();
            end
        endcase
        if (step_cmds.size() == 0)
            emit_cmd(OP_NONE, '0);
        step_cmds[step_cmds.size() - 1].last = 1'b1;
        foreach (step_cmds[i])
            cmd_expect_q.push_back(step_cmds[i]);
    endfunction

    // monitor: checks each command word, predicts on each character word, tracks colours
    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_col = 0;
            cur_row = 0;
            fore_q = FORE_RESET;
            back_q = BACK_RESET;
            stuck_cycles = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (cmd_expect_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected command: op=%0d x=%0d y=%0d glyph=%h last=%b",
                                 m_op_kind, m_pixel_x, m_pixel_y, m_glyph_bits, m_last);
                    mismatch_count++;
                end else begin
                    exp_cmd = cmd_expect_q.pop_front();
                    if (m_op_kind !== exp_cmd.op || m_pixel_x !== exp_cmd.px ||
                        m_pixel_y !== exp_cmd.py || m_glyph_bits !== exp_cmd.glyph ||
                        m_draw_fore !== exp_cmd.fore || m_draw_back !== exp_cmd.back ||
                        m_last !== exp_cmd.last) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch exp: op=%0d x=%0d y=%0d glyph=%h fg=%h bg=%h last=%b",
                                     exp_cmd.op, exp_cmd.px, exp_cmd.py, exp_cmd.glyph,
                                     exp_cmd.fore, exp_cmd.back, exp_cmd.last);
                            $display("         got: op=%0d x=%0d y=%0d glyph=%h fg=%h bg=%h last=%b",
                                     m_op_kind, m_pixel_x, m_pixel_y, m_glyph_bits,
                                     m_draw_fore, m_draw_back, m_last);
                        end
                        mismatch_count++;
                    end
                    cmds_checked++;
                end
            end
            if (s_valid && s_ready)
                predict_char(s_char_code);
            if (cfg_we) begin
                if (cfg_index == REG_FORE)
                    fore_q = cfg_data;
                else
                    back_q = cfg_data;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no word moved for %0d cycles, %0d commands outstanding",
                             stuck_cycles, cmd_expect_q.size());
                    $display("text_console_cursor_engine_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    // receiver: random stall before each command word, or a long hold when asked
    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (rx_hold_req > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_req) @(posedge aclk);
                rx_hold_req = 0;
            end else begin
                rx_stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
                if (rx_stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (rx_stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // valid is left high after a word so that a back-to-back word needs no drop
    task automatic send_char(input logic [7:0] code);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            if (tx_valid_up)
                s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= code;
        do @(posedge aclk); while (!s_ready);
        tx_valid_up = 1'b1;
        chars_sent++;
    endtask

    task automatic wait_drained();
        if (tx_valid_up) begin
            s_valid <= 1'b0;
            tx_valid_up = 1'b0;
        end
        do @(posedge aclk); while (cmd_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_colours(input colour_t fore, input colour_t back);
        cfg_we <= 1'b1;
        cfg_index <= REG_FORE;
        cfg_data <= fore;
        @(posedge aclk);
        cfg_index <= REG_BACK;
        cfg_data <= back;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // every control code, glyph extremes, codes without a glyph, backspace at home
    // and across a row, tab from the last column and from mid row
    task automatic test_control_codes();
        logic [7:0] codes [20] = '{
            8'h41, 8'h30, 8'h7F, CH_SPACE, 8'h00, 8'h1F, 8'h0B, 8'h80, 8'hFF,
            CH_BEL, CH_ETX, CH_BS, CH_LF, CH_BS, CH_TAB, CH_TAB, CH_CR, 8'h21,
            CH_TAB, CH_FF
        };
        foreach (codes[i])
            send_char(codes[i]);
        wait_drained();
    endtask

    task automatic test_colour_extremes();
        colour_t fores [4] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
        colour_t backs [4] = '{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};
        foreach (fores[i]) begin
            write_colours(fores[i], backs[i]);
            send_char(8'h41);
            send_char(CH_SPACE);
            send_char(CH_BS);
            send_char(8'h7E);
            send_char(CH_FF);
            wait_drained();
        end
    endtask

    // fill down to the last row and tab across it so the final tab wraps and clears,
    // with a long receiver hold early on and the sender offering back to back
    task automatic test_screen_full_under_backpressure();
        tx_gap_max = 0;
        rx_hold_req = HOLD_CYCLES;
        send_char(CH_FF);
        repeat (ROWS_DEF - 1) send_char(CH_LF);
        repeat (COLUMNS_DEF / TAB_STOP) send_char(CH_TAB);
        wait_drained();
        tx_gap_max = 15;
        send_char(8'h5A);
        send_char(CH_BS);
        wait_drained();
    endtask

    task automatic test_random_text();
        int         target;
        int         r;
        int         n;
        int         pick;
        logic [7:0] code;
        for (int phase = 0; phase < 4; phase++) begin
            tx_gap_max = (phase % 2 == 0) ? 15 : 0;
            rx_stall_max = (phase < 2) ? 15 : 0;
            write_colours(16'($urandom), 16'($urandom));
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    // a line of text ending in CR or LF, now and then one that wraps
                    n = (r < 45) ? $urandom_range(0, 8) : $urandom_range(40, 60);
                    repeat (n) begin
                        if ($urandom_range(0, 15) == 0)
                            code = 8'($urandom);
                        else if ($urandom_range(0, 9) == 0)
                            code = CH_SPACE;
                        else
                            code = 8'($urandom_range(33, 127));
                        send_char(code);
                    end
                    send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
                end else if (r < 65) begin
                    repeat ($urandom_range(1, 14)) send_char(CH_TAB);
                end else if (r < 75) begin
                    repeat ($urandom_range(2, 8)) send_char(CH_LF);
                end else begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 30)
                            code = 8'($urandom_range(32, 127));
                        else if (pick < 42)
                            code = CH_BS;
                        else if (pick < 48)
                            code = CH_FF;
                        else if (pick < 56)
                            code = CH_BEL;
                        else if (pick < 62)
                            code = CH_ETX;
                        else if (pick < 80)
                            code = 8'($urandom_range(0, 31));
                        else
                            code = 8'($urandom_range(128, 255));
                        send_char(code);
                    end
                end
            end
            wait_drained();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_FORE;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_char_code <= '0;
        m_ready <= 1'b0;
        tx_gap_max = 15;
        rx_stall_max = 15;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_control_codes();
        test_colour_extremes();
        test_screen_full_under_backpressure();
        test_random_text();
        wait_drained();

        $display("covered %0d characters, %0d drawing commands, %0d screen clears",
                 chars_sent, cmds_checked, clears_predicted);
        $display("colour settings written: %0d, mismatches: %0d", settings_used, mismatch_count);
        if (mismatch_count == 0 && cmd_expect_q.size() == 0)
            $display("text_console_cursor_engine_tb: done, clean");
        else
            $display("text_console_cursor_engine_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/tcce_pkg.sv
rtl/tcce_font_rom.sv
rtl/text_console_cursor_engine.sv
tb/text_console_cursor_engine_tb.sv
